@@ src/plbf_pkg.sv @@
`default_nettype none

package plbf_pkg;

	// Field widths fixed by the stream and register formats.
	localparam int SAMPLE_W = 16;
	localparam int GRAM_W   = 48;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;

	// ln(2) in unsigned Q0.32.
	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS_USED     = 3'd0,
		REG_VARS_USED     = 3'd1,
		REG_PRIOR_SHAPE   = 3'd2,
		REG_PRIOR_RATE    = 3'd3,
		REG_PRIOR_SCALE   = 3'd4,
		REG_SHARED_OFFSET = 3'd5
	} reg_idx_t;

	// Prior settings handed to the pair evaluator.
	typedef struct packed {
		logic [8:0]         rows_used;
		logic [31:0]        prior_shape;
		logic [31:0]        prior_rate;
		logic [31:0]        prior_scale;
		logic signed [31:0] shared_offset;
	} prior_cfg_t;

	// Result of one pair evaluation.
	typedef struct packed {
		logic               done;
		logic               invalid;
		logic signed [31:0] value;
	} pair_result_t;

endpackage

`default_nettype wire

@@ src/pairwise_log_bayes_factor_core.sv @@
`default_nettype none

// Channel     | Direction | Contents
// s_axis      | in        | tdata[15:0] sample (Q8.8); tlast last_sample
// m_axis      | out       | tdata row_var, col_var, log_factor; tuser invalid; tlast
// cfg         | in        | cfg_we, cfg_index, cfg_data (write only)
//
// A sample in column c is accepted, then updates the sums (k, c) for k = 0
// to c by read-modify-write through the single gram read port, then drains.
// After the last sample each diagonal result is emitted directly; each
// off-diagonal one waits on the serial square, the two serial divisions
// and the log sequence of the pair evaluator.
// Reset clears the sums through per-entry valid bits; no clearing pass.
// A stalled output holds the next result back; the block accepts a new
// sample as soon as the final result sits in the output register.
module pairwise_log_bayes_factor_core #(
	parameter int MAX_VARS = 8,
	parameter int MAX_ROWS = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [plbf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [plbf_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [15:0]                       s_axis_tdata,  // [15:0] sample
	input  wire logic                              s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// [2:0] row_var, [5:3] col_var, [37:6] log_factor, [39:38] zero
	output logic [39:0]                            m_axis_tdata,
	output logic                                   m_axis_tuser,  // [0] invalid
	output logic                                   m_axis_tlast
);

	localparam int DEPTH = MAX_VARS * MAX_VARS;
	localparam int AW    = $clog2(DEPTH);
	localparam int VW    = $clog2(MAX_VARS);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam logic [AW-1:0] NV_A    = AW'(MAX_VARS);
	localparam logic [RW-1:0] ROW_MAX = RW'(MAX_ROWS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ACC, ST_DRAIN, ST_PAIR, ST_RA, ST_RB, ST_RC, ST_WAIT, ST_EMIT
	} state_t;

	state_t                               state_q;
	logic [8:0]                           rows_used_q;
	logic [3:0]                           vars_used_q;
	logic [31:0]                          shape_q;
	logic [31:0]                          rate_q;
	logic [31:0]                          scale_q;
	logic signed [31:0]                   offset_q;
	logic [3:0]                           p_eff;
	logic [VW-1:0]                        col_q;
	logic [RW-1:0]                        rows_q;
	logic signed [15:0]                   rbuf_q [MAX_VARS];
	logic signed [15:0]                   smp_q;
	logic                                 last_q;
	logic [VW-1:0]                        c_q;
	logic [VW-1:0]                        k_q;
	logic                                 v_s1;
	logic [AW-1:0]                        addr_s1;
	logic signed [31:0]                   prod_s1;
	logic [VW-1:0]                        i_q;
	logic [VW-1:0]                        j_q;
	logic signed [plbf_pkg::GRAM_W-1:0]   sii_q;
	logic signed [plbf_pkg::GRAM_W-1:0]   sjj_q;
	logic signed [plbf_pkg::GRAM_W-1:0]   sij_q;
	logic                                 start_q;
	logic signed [31:0]                   val_q;
	logic                                 bad_q;
	logic                                 mvalid_q;
	logic [39:0]                          mdata_q;
	logic                                 muser_q;
	logic                                 mlast_q;

	logic                                 rd_en;
	logic [AW-1:0]                        rd_addr;
	logic signed [plbf_pkg::GRAM_W-1:0]   rd_data;
	logic signed [plbf_pkg::GRAM_W-1:0]   wr_data;
	logic                                 clr;
	logic                                 accept;
	logic                                 out_load;
	logic                                 pair_last;
	logic                                 col_wrap;
	plbf_pkg::prior_cfg_t                 pcfg;
	plbf_pkg::pair_result_t               pres;

	// Entry of the upper triangle that holds the pair (a, b).
	function automatic logic [AW-1:0] gaddr(input logic [VW-1:0] a, input logic [VW-1:0] b);
		logic [VW-1:0] lo;
		logic [VW-1:0] hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return AW'(lo) * NV_A + AW'(hi);
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_used_q <= 9'd1;
			vars_used_q <= 4'd2;
			shape_q     <= 32'h0001_0000;
			rate_q      <= 32'h0001_0000;
			scale_q     <= 32'h0001_0000;
			offset_q    <= '0;
		end else if (cfg_we) begin
			unique case (plbf_pkg::reg_idx_t'(cfg_index))
				plbf_pkg::REG_ROWS_USED:     rows_used_q <= cfg_data[8:0];
				plbf_pkg::REG_VARS_USED:     vars_used_q <= cfg_data[3:0];
				plbf_pkg::REG_PRIOR_SHAPE:   shape_q     <= cfg_data;
				plbf_pkg::REG_PRIOR_RATE:    rate_q      <= cfg_data;
				plbf_pkg::REG_PRIOR_SCALE:   scale_q     <= cfg_data;
				plbf_pkg::REG_SHARED_OFFSET: offset_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective column count, clamped to the supported range.
	always_comb begin
		if (vars_used_q < 4'd2) begin
			p_eff = 4'd2;
		end else if (vars_used_q > 4'(MAX_VARS)) begin
			p_eff = 4'(MAX_VARS);
		end else begin
			p_eff = vars_used_q;
		end
	end

	assign pcfg = '{rows_used: rows_used_q, prior_shape: shape_q, prior_rate: rate_q,
		prior_scale: scale_q, shared_offset: offset_q};

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign col_wrap      = (4'(col_q) + 4'd1) >= p_eff;
	assign pair_last     = (4'(i_q) + 4'd1 == p_eff) && (4'(j_q) + 4'd1 == p_eff);
	assign out_load      = (state_q == ST_EMIT) && (!mvalid_q || m_axis_tready);
	assign clr           = out_load && pair_last;
	assign wr_data       = rd_data + 48'(prod_s1);

	// Memory read port is shared by accumulation and result readout.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			ST_ACC: begin
				rd_en   = 1'b1;
				rd_addr = AW'(k_q) * NV_A + AW'(c_q);
			end
			ST_PAIR: begin
				rd_en   = (i_q != j_q);
				rd_addr = gaddr(i_q, i_q);
			end
			ST_RA: begin
				rd_en   = 1'b1;
				rd_addr = gaddr(j_q, j_q);
			end
			ST_RB: begin
				rd_en   = 1'b1;
				rd_addr = gaddr(i_q, j_q);
			end
			default: ;
		endcase
	end

	// Row buffer holds the current row for the cross products.
	always_ff @(posedge clk) begin
		if (accept) begin
			rbuf_q[col_q] <= $signed(s_axis_tdata);
			smp_q         <= $signed(s_axis_tdata);
			last_q        <= s_axis_tlast;
			c_q           <= col_q;
		end
		if (state_q == ST_ACC) begin
			prod_s1 <= rbuf_q[k_q] * smp_q;
			addr_s1 <= rd_addr;
		end
		unique case (state_q)
			ST_RA:   sii_q <= rd_data;
			ST_RB:   sjj_q <= rd_data;
			ST_RC:   sij_q <= rd_data;
			default: ;
		endcase
	end

	// Main sequencer: accumulation, then one result per ordered pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			col_q    <= '0;
			rows_q   <= '0;
			k_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
			v_s1     <= 1'b0;
			start_q  <= 1'b0;
			val_q    <= '0;
			bad_q    <= 1'b0;
			mvalid_q <= 1'b0;
			mdata_q  <= '0;
			muser_q  <= 1'b0;
			mlast_q  <= 1'b0;
		end else begin
			v_s1    <= (state_q == ST_ACC);
			start_q <= (state_q == ST_RC);
			if (out_load) begin
				mvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				mvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q <= '0;
						i_q <= '0;
						j_q <= '0;
						if (col_wrap) begin
							col_q <= '0;
							if (rows_q < ROW_MAX) begin
								rows_q <= rows_q + RW'(1);
							end
						end else begin
							col_q <= col_q + VW'(1);
						end
						if (rows_q < ROW_MAX) begin
							state_q <= ST_ACC;
						end else if (s_axis_tlast) begin
							state_q <= ST_PAIR;
						end
					end
				end
				ST_ACC: begin
					if (k_q == c_q) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + VW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= last_q ? ST_PAIR : ST_IDLE;
				end
				ST_PAIR: begin
					if (i_q == j_q) begin
						val_q   <= '0;
						bad_q   <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_RA;
					end
				end
				ST_RA: state_q <= ST_RB;
				ST_RB: state_q <= ST_RC;
				ST_RC: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (pres.done) begin
						val_q   <= pres.value;
						bad_q   <= pres.invalid;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						mdata_q  <= {2'd0, val_q, 3'(j_q), 3'(i_q)};
						muser_q  <= bad_q;
						mlast_q  <= pair_last;
						if (pair_last) begin
							col_q   <= '0;
							rows_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							if (4'(j_q) + 4'd1 == p_eff) begin
								j_q <= '0;
								i_q <= i_q + VW'(1);
							end else begin
								j_q <= j_q + VW'(1);
							end
							state_q <= ST_PAIR;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	plbf_gram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_gram (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (v_s1),
		.wr_addr(addr_s1),
		.wr_data(wr_data)
	);

	plbf_pair u_pair (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.sii   (sii_q),
		.sjj   (sjj_q),
		.sij   (sij_q),
		.cfg   (pcfg),
		.res   (pres)
	);

	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = mdata_q;
	assign m_axis_tuser  = muser_q;
	assign m_axis_tlast  = mlast_q;

	// Sum write-backs only trail the accumulation reads.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_ACC || state_q == ST_DRAIN))
		else $error("gram write outside accumulation");

	// A write-back never targets the entry being read in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && rd_en) |-> (addr_s1 != rd_addr))
		else $error("gram read and write collide");

	// The pair evaluator is started only after the three sums were read.
	assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (state_q == ST_WAIT && $past(state_q) == ST_RC))
		else $error("pair start out of sequence");

	// The final result returns the block to idle with a fresh row position.
	assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (state_q == ST_IDLE && col_q == '0 && rows_q == '0 && m_axis_tlast))
		else $error("run not closed after final result");

endmodule

`default_nettype wire

@@ src/plbf_gram.sv @@
`default_nettype none

// Gram sum memory: one write and one registered read per cycle.
// Entries that were never written since the last clear read as zero.
module plbf_gram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 clr,
	input  wire logic                                 rd_en,
	input  wire logic [AW-1:0]                        rd_addr,
	output logic signed [plbf_pkg::GRAM_W-1:0]        rd_data,
	input  wire logic                                 wr_en,
	input  wire logic [AW-1:0]                        wr_addr,
	input  wire logic signed [plbf_pkg::GRAM_W-1:0]   wr_data
);

	logic signed [plbf_pkg::GRAM_W-1:0] mem_q [DEPTH];
	logic signed [plbf_pkg::GRAM_W-1:0] rd_raw_q;
	logic [DEPTH-1:0]                   valid_q;
	logic                               rd_hit_q;

	// Storage array and its registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	// Per-entry valid bits give the cleared state without a sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_hit_q <= valid_q[rd_addr];
			end
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

@@ src/plbf_pair.sv @@
`default_nettype none

// Evaluates one off-diagonal log Bayes factor from Sii, Sjj and Sij.
// Serial squaring, two restoring divisions, a normalizing shift, sixteen
// squaring steps for log2, and two registered scaling products.
module plbf_pair (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [plbf_pkg::GRAM_W-1:0]  sii,
	input  wire logic signed [plbf_pkg::GRAM_W-1:0]  sjj,
	input  wire logic signed [plbf_pkg::GRAM_W-1:0]  sij,
	input  wire plbf_pkg::prior_cfg_t                cfg,
	output plbf_pkg::pair_result_t                   res
);

	typedef enum logic [3:0] {
		P_IDLE, P_SQ, P_DIV, P_SETQ, P_ARG1, P_ARG2, P_NORM,
		P_SQR, P_L2, P_LN, P_CM, P_RND, P_RES
	} pstate_t;

	pstate_t                  st_q;
	logic [6:0]               cnt_q;
	logic                     div2_q;
	logic [95:0]              dvd_q;
	logic [47:0]              rem_q;
	logic [47:0]              dsr_q;
	logic [47:0]              sii_q;
	logic [47:0]              sjj_q;
	logic [48:0]              x_q;
	logic [5:0]               m_q;
	logic [30:0]              y_q;
	logic [15:0]              frac_q;
	logic [54:0]              lprod_q;
	logic                     lneg_q;
	logic [22:0]              lnmag_q;
	logic [55:0]              cprod_q;
	logic [39:0]              rnd_q;
	plbf_pkg::pair_result_t   res_q;

	logic [47:0]              mag;
	logic [48:0]              sq_sum;
	logic [48:0]              r2;
	logic                     ge;
	logic [63:0]              qv;
	logic [47:0]              qc;
	logic [48:0]              arg;
	logic [61:0]              ysq;
	logic [31:0]              yy;
	logic signed [6:0]        lsig;
	logic signed [22:0]       l2;
	logic [22:0]              lmag;
	logic [32:0]              coef;
	logic signed [49:0]       pm;
	logic signed [49:0]       rsum;
	logic                     fin;

	// Datapath pieces used by the sequencer below.
	always_comb begin
		mag    = sij[47] ? 48'(-sij) : 48'(sij);
		sq_sum = {1'b0, dvd_q[95:48]} + (dvd_q[0] ? {1'b0, dsr_q} : 49'd0);
		r2     = {rem_q, dvd_q[95]};
		ge     = r2 >= {1'b0, dsr_q};
		qv     = dvd_q[63:0];
		qc     = (qv > {16'd0, sii_q}) ? sii_q : qv[47:0];
		arg    = {1'b0, x_q[48:1]} + 49'(cfg.prior_rate);
		ysq    = 62'(y_q) * 62'(y_q);
		yy     = ysq[61:30];
		lsig   = $signed({1'b0, m_q}) - 7'sd16;
		l2     = {lsig, frac_q};
		lmag   = lsig[6] ? 23'(-l2) : 23'(l2);
		coef   = 33'({cfg.rows_used, 15'd0}) + 33'(cfg.prior_shape);
		pm     = lneg_q ? -$signed({10'd0, rnd_q}) : $signed({10'd0, rnd_q});
		rsum   = 50'(cfg.shared_offset) + $signed({3'd0, sii_q[47:1]}) - pm;
		// A result is loaded into the result register at the end of this cycle.
		fin    = (st_q == P_IDLE && start && (sjj[47] || sjj == '0 || sii[47])) ||
			(st_q == P_ARG2 && arg == '0) || (st_q == P_RES);
	end

	// Sequencer for one evaluation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= P_IDLE;
			res_q  <= '0;
			cnt_q  <= '0;
			div2_q <= 1'b0;
		end else begin
			if (!fin) begin
				res_q.done <= 1'b0;
			end
			unique case (st_q)
				P_IDLE: begin
					if (start) begin
						if (sjj[47] || sjj == '0 || sii[47]) begin
							res_q <= '{done: 1'b1, invalid: 1'b1, value: '0};
						end else begin
							sii_q  <= sii;
							sjj_q  <= sjj;
							dvd_q  <= {48'd0, mag};
							dsr_q  <= mag;
							cnt_q  <= 7'd48;
							div2_q <= 1'b0;
							st_q   <= P_SQ;
						end
					end
				end
				P_SQ: begin
					dvd_q <= {sq_sum, dvd_q[47:1]};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						dsr_q <= sjj_q;
						rem_q <= '0;
						cnt_q <= 7'd96;
						st_q  <= P_DIV;
					end
				end
				P_DIV: begin
					rem_q <= ge ? 48'(r2 - {1'b0, dsr_q}) : r2[47:0];
					dvd_q <= {dvd_q[94:0], ge};
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						st_q <= div2_q ? P_ARG1 : P_SETQ;
					end
				end
				P_SETQ: begin
					// Quotient scaled by 2^16 over 1 + gamma.
					dvd_q  <= {dvd_q[47:0], 48'd0};
					rem_q  <= '0;
					dsr_q  <= 48'(33'h1_0000 + 33'(cfg.prior_scale));
					cnt_q  <= 7'd64;
					div2_q <= 1'b1;
					st_q   <= P_DIV;
				end
				P_ARG1: begin
					x_q  <= {1'b0, sii_q - qc};
					st_q <= P_ARG2;
				end
				P_ARG2: begin
					if (arg == '0) begin
						res_q <= '{done: 1'b1, invalid: 1'b1, value: '0};
						st_q  <= P_IDLE;
					end else begin
						x_q  <= arg;
						m_q  <= 6'd48;
						st_q <= P_NORM;
					end
				end
				P_NORM: begin
					if (x_q[48]) begin
						y_q    <= x_q[48:18];
						frac_q <= '0;
						cnt_q  <= 7'd16;
						st_q   <= P_SQR;
					end else begin
						x_q <= {x_q[47:0], 1'b0};
						m_q <= m_q - 6'd1;
					end
				end
				P_SQR: begin
					frac_q <= {frac_q[14:0], yy[31]};
					y_q    <= yy[31] ? yy[31:1] : yy[30:0];
					cnt_q  <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						st_q <= P_L2;
					end
				end
				P_L2: begin
					lprod_q <= 55'(lmag) * 55'(plbf_pkg::LN2_Q32);
					lneg_q  <= lsig[6];
					st_q    <= P_LN;
				end
				P_LN: begin
					lnmag_q <= 23'((56'(lprod_q) + 56'h8000_0000) >> 32);
					st_q    <= P_CM;
				end
				P_CM: begin
					cprod_q <= 56'(coef) * 56'(lnmag_q);
					st_q    <= P_RND;
				end
				P_RND: begin
					rnd_q <= 40'((57'(cprod_q) + 57'h8000) >> 16);
					st_q  <= P_RES;
				end
				P_RES: begin
					res_q.done    <= 1'b1;
					res_q.invalid <= 1'b0;
					if (rsum > 50'sh7FFF_FFFF) begin
						res_q.value <= 32'sh7FFF_FFFF;
					end else if (rsum < -50'sh8000_0000) begin
						res_q.value <= 32'sh8000_0000;
					end else begin
						res_q.value <= 32'(rsum);
					end
					st_q <= P_IDLE;
				end
				default: st_q <= P_IDLE;
			endcase
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

@@ bench/bayes_factor_checker.sv @@
`default_nettype none

module bayes_factor_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [39:0] m_axis_tdata,
	input  wire logic        m_axis_tuser,
	input  wire logic        m_axis_tlast,
	output int               errors,
	output int               pending
);

	localparam int NV = 8;
	localparam int NR = 256;

	typedef struct {
		bit [2:0]  row_var;
		bit [2:0]  col_var;
		bit [31:0] log_factor;
		bit        invalid;
		bit        last;
	} pair_result_s;

	pair_result_s expected_pairs[$];

	// Shadow registers, kept at 64 bits with the proper extension.
	longint n_rows, n_vars, a0, b0, gamma, offset;

	// Shadow of the accumulation state.
	longint gram[NV*NV];
	longint row_buf[NV];
	int     col_pos;
	int     row_cnt;

	function automatic int eff_vars();
		if (n_vars < 2) return 2;
		if (n_vars > NV) return NV;
		return int'(n_vars);
	endfunction

	function automatic longint gram_pair(int a, int b);
		int lo, hi;
		lo = a < b ? a : b;
		hi = a < b ? b : a;
		return gram[lo*NV + hi];
	endfunction

	// Round a signed product down by sh bits, ties away from zero.
	function automatic longint round_shift(longint prod, int sh);
		longint unsigned half, mag;
		half = 64'd1 << (sh - 1);
		if (prod >= 0) begin
			mag = prod;
			return longint'((mag + half) >> sh);
		end
		mag = -prod;
		return -longint'((mag + half) >> sh);
	endfunction

	// Natural log of a positive Q16.16 value, via log2 by repeated squaring.
	function automatic longint ln_fixed(longint unsigned x);
		int m;
		longint unsigned y;
		longint l2, frac;
		m = 63;
		frac = 0;
		while (m > 0 && x[m] == 1'b0) m--;
		y = m > 30 ? x >> (m - 30) : x << (30 - m);
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 30;
			frac = frac << 1;
			if (y >= (64'd1 << 31)) begin
				frac = frac | 1;
				y = y >> 1;
			end
		end
		l2 = longint'(m - 16) * 65536 + frac;
		return round_shift(l2 * longint'(plbf_pkg::LN2_Q32), 32);
	endfunction

	// Log Bayes factor of one off-diagonal pair.
	function automatic void predict_pair(int i, int j, output bit [31:0] val, output bit bad);
		longint sii, sjj, sij, lnv, coef, res;
		longint unsigned mag, t, q, arg;
		bit [127:0] sq;
		sii = gram_pair(i, i);
		sjj = gram_pair(j, j);
		sij = gram_pair(i, j);
		val = '0;
		bad = 1'b1;
		if (sjj <= 0 || sii < 0) return;
		mag = sij < 0 ? -sij : sij;
		sq = {64'd0, mag} * {64'd0, mag};
		t = 64'(sq / {64'd0, sjj});
		q = (t << 16) / (64'd65536 + longint'(gamma));
		if (q > longint'(sii)) q = sii;
		arg = ((longint'(sii) - q) >> 1) + longint'(b0);
		if (arg == 0) return;
		lnv = ln_fixed(arg);
		coef = n_rows * 32768 + a0;
		res = offset + longint'(longint'(sii) >>> 1) - round_shift(coef * lnv, 16);
		if (res > 64'sd2147483647) res = 64'sd2147483647;
		if (res < -64'sd2147483648) res = -64'sd2147483648;
		val = res[31:0];
		bad = 1'b0;
	endfunction

	// Take one sample in; on the last one queue every pair of the matrix.
	task automatic take_sample(bit [15:0] raw, bit last);
		int p, c;
		longint s;
		pair_result_s r;
		p = eff_vars();
		c = col_pos % NV;
		s = longint'($signed(raw));
		row_buf[c] = s;
		if (row_cnt < NR)
			for (int k = 0; k <= c; k++) gram[k*NV + c] += row_buf[k] * s;
		if (c + 1 >= p) begin
			col_pos = 0;
			if (row_cnt < NR) row_cnt++;
		end else begin
			col_pos = c + 1;
		end
		if (!last) return;
		for (int i = 0; i < p; i++) begin
			for (int j = 0; j < p; j++) begin
				r.row_var = i[2:0];
				r.col_var = j[2:0];
				r.log_factor = '0;
				r.invalid = 1'b0;
				if (i != j) predict_pair(i, j, r.log_factor, r.invalid);
				r.last = (i == p - 1) && (j == p - 1);
				expected_pairs.push_back(r);
			end
		end
		foreach (gram[k]) gram[k] = 0;
		col_pos = 0;
		row_cnt = 0;
	endtask

	task automatic compare_result();
		pair_result_s e;
		if (expected_pairs.size() == 0) begin
			$display("%0t: unexpected result: expected none, actual tdata %h", $time,
				m_axis_tdata);
			errors++;
			return;
		end
		e = expected_pairs.pop_front();
		if (m_axis_tdata[2:0] !== e.row_var) begin
			$display("%0t: row_var expected %0d actual %0d", $time, e.row_var,
				m_axis_tdata[2:0]);
			errors++;
		end
		if (m_axis_tdata[5:3] !== e.col_var) begin
			$display("%0t: col_var expected %0d actual %0d", $time, e.col_var,
				m_axis_tdata[5:3]);
			errors++;
		end
		if (m_axis_tdata[37:6] !== e.log_factor) begin
			$display("%0t: log_factor (%0d,%0d) expected %h actual %h", $time, e.row_var,
				e.col_var, e.log_factor, m_axis_tdata[37:6]);
			errors++;
		end
		if (m_axis_tdata[39:38] !== 2'b00) begin
			$display("%0t: tdata pad expected 0 actual %b", $time, m_axis_tdata[39:38]);
			errors++;
		end
		if (m_axis_tuser !== e.invalid) begin
			$display("%0t: invalid (%0d,%0d) expected %b actual %b", $time, e.row_var,
				e.col_var, e.invalid, m_axis_tuser);
			errors++;
		end
		if (m_axis_tlast !== e.last) begin
			$display("%0t: last_result expected %b actual %b", $time, e.last, m_axis_tlast);
			errors++;
		end
	endtask

	initial errors = 0;
	assign pending = expected_pairs.size();

	// Sample all channels at the rising edge, before the block updates.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_rows = 1;
			n_vars = 2;
			a0 = 65536;
			b0 = 65536;
			gamma = 65536;
			offset = 0;
			foreach (gram[k]) gram[k] = 0;
			foreach (row_buf[k]) row_buf[k] = 0;
			col_pos = 0;
			row_cnt = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) compare_result();
			if (cfg_we) begin
				case (plbf_pkg::reg_idx_t'(cfg_index))
					plbf_pkg::REG_ROWS_USED:     n_rows = longint'(cfg_data[8:0]);
					plbf_pkg::REG_VARS_USED:     n_vars = longint'(cfg_data[3:0]);
					plbf_pkg::REG_PRIOR_SHAPE:   a0 = longint'(cfg_data);
					plbf_pkg::REG_PRIOR_RATE:    b0 = longint'(cfg_data);
					plbf_pkg::REG_PRIOR_SCALE:   gamma = longint'(cfg_data);
					plbf_pkg::REG_SHARED_OFFSET: offset = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) take_sample(s_axis_tdata, s_axis_tlast);
		end
	end

endmodule

`default_nettype wire

@@ bench/tb_pairwise_log_bayes_factor_core.sv @@
`default_nettype none

module tb_pairwise_log_bayes_factor_core;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	int          errors;
	int          pending;

	int burst_left;
	int vars_eff;
	int sent_items;
	bit hold_req;
	int hold_cnt;
	int rx_mode;
	int rx_left;

	pairwise_log_bayes_factor_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	bayes_factor_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#200000000;
		$display("Regression FAIL");
		$finish;
	end

	// Result side: random ready patterns, plus a long hold-off on request.
	initial begin
		m_axis_tready = 1'b0;
		hold_cnt = 0;
		rx_left = 0;
		rx_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 800;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(20, 200);
				end
				rx_left--;
				case (rx_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 1);
					2: m_axis_tready <= ($urandom_range(0, 7) != 0);
					default: m_axis_tready <= ($urandom_range(0, 15) == 0);
				endcase
			end
		end
	end

	// Offer one request; called and returning at a falling edge.
	task automatic send_sample(bit [15:0] d, bit last);
		int gap;
		bit rdy;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= last;
		forever begin
			#1 rdy = s_axis_tready;
			@(posedge clk);
			if (rdy) break;
			@(negedge clk);
		end
		@(negedge clk);
		burst_left--;
		sent_items++;
	endtask

	// Park the sender, wait for every result, then let the block settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (40) @(posedge clk);
		@(negedge clk);
	endtask

	// Write all six registers while the block is idle.
	task automatic program_regs(bit [31:0] rows, bit [31:0] vars, bit [31:0] shape,
			bit [31:0] rate, bit [31:0] scale, bit [31:0] offs);
		bit [31:0] vals[6];
		plbf_pkg::reg_idx_t idx[6];
		vals = '{rows, vars, shape, rate, scale, offs};
		idx = '{plbf_pkg::REG_ROWS_USED, plbf_pkg::REG_VARS_USED, plbf_pkg::REG_PRIOR_SHAPE,
			plbf_pkg::REG_PRIOR_RATE, plbf_pkg::REG_PRIOR_SCALE, plbf_pkg::REG_SHARED_OFFSET};
		for (int k = 0; k < 6; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= vals[k];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		vars_eff = vars[3:0] < 2 ? 2 : (vars[3:0] > 8 ? 8 : int'(vars[3:0]));
	endtask

	// Stream a matrix; cut drops trailing elements so the run ends mid-row.
	// Kinds: 0 full range, 1 small, 2 extremes, 3 identical columns,
	// 4 first column zero.
	task automatic send_matrix(int rows, int kind, int cut, bit hold_at_end);
		int total, c;
		bit [15:0] row_val, d;
		total = rows * vars_eff - cut;
		if (total < 1) total = 1;
		for (int n = 0; n < total; n++) begin
			c = n % vars_eff;
			if (c == 0) row_val = $urandom;
			case (kind)
				0: d = $urandom;
				1: d = 16'($urandom_range(0, 1023) - 512);
				2: begin
					case ($urandom_range(0, 4))
						0: d = 16'h8000;
						1: d = 16'h7fff;
						2: d = 16'hffff;
						3: d = 16'h0001;
						default: d = 16'h0000;
					endcase
				end
				3: d = row_val;
				default: d = (c == 0) ? 16'h0000 : 16'($urandom);
			endcase
			if (hold_at_end && n == total - 1) hold_req = 1'b1;
			send_sample(d, n == total - 1);
		end
	endtask

	function automatic bit [31:0] rand_q16();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 8)) << 15;
			1: return $urandom_range(0, 262143);
			2: return $urandom;
			default: return 32'h0001_0000;
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		hold_req = 1'b0;
		burst_left = 0;
		sent_items = 0;
		vars_eff = 2;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings, extreme sample values.
		send_matrix(3, 2, 0, 1'b0);
		drain();

		// All registers at their low end: zero divisor and zero log argument.
		program_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000);
		send_matrix(2, 4, 0, 1'b0);
		drain();
		send_matrix(3, 3, 0, 1'b0);
		drain();

		// All registers at their high end, extreme samples to saturate.
		program_regs(32'd511, 32'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'h7fff_ffff);
		send_matrix(2, 2, 0, 1'b0);
		drain();

		// Last sample in the middle of a row, then a long output hold-off
		// while the next matrix queues up behind it.
		program_regs(32'd4, 32'd3, 32'h0002_0000, 32'h0000_8000, 32'h0000_4000,
			32'hffff_0000);
		send_matrix(3, 1, 2, 1'b1);
		send_matrix(2, 0, 0, 1'b0);
		drain();

		// Random settings and matrices.
		while (sent_items < 110) begin
			program_regs($urandom_range(0, 511), $urandom_range(0, 15), rand_q16(),
				rand_q16(), rand_q16(), ($urandom_range(0, 1) ? $urandom :
				32'($signed($urandom_range(0, 2000000)) - 1000000)));
			repeat (2) begin
				send_matrix($urandom_range(1, 4), $urandom_range(0, 4),
					($urandom_range(0, 3) == 0) ? $urandom_range(1, vars_eff - 1) : 0,
					1'b0);
			end
			drain();
		end

		wait (pending == 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
src/plbf_pkg.sv
src/plbf_gram.sv
src/plbf_pair.sv
src/pairwise_log_bayes_factor_core.sv
bench/bayes_factor_checker.sv
bench/tb_pairwise_log_bayes_factor_core.sv
